// ----- src/c8core_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// c8core_pkg
// Shared constants, command and status types of the CHIP-8 interpreter core.
// ----------------------------------------------------------------------------
package c8core_pkg;

    localparam int ADDR_W       = 12;
    localparam int MEM_BYTES    = 4096;
    localparam int SCREEN_W     = 64;
    localparam int SCREEN_H     = 32;
    localparam int ROW_W        = 5;
    localparam int STACK_DEPTH  = 16;
    localparam int FONT_BYTES   = 80;
    localparam int S_DATA_W     = 56;
    localparam int M_DATA_W     = 96;

    localparam logic [ADDR_W-1:0] PROGRAM_BASE = 12'h200;
    localparam logic [ADDR_W-1:0] FONT_BASE    = 12'h050;
    localparam logic [ADDR_W-1:0] ADDR_LAST    = 12'hFFF;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_EXEC  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] GLYPHS [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef enum logic [4:0] {
        A_NONE, A_CLEAR, A_ACCEPT, A_FETCH_HI, A_FETCH_LO, A_DECODE, A_EXEC,
        A_DRAW_RD, A_DRAW_WR, A_BCD, A_STORE_RD, A_STORE_WR, A_LOAD_RD,
        A_LOAD_WR, A_WRITE_VF, A_WRITE_VX, A_TICK, A_OUT
    } act_t;

    typedef enum logic [2:0] {
        CL_NONE, CL_WX, CL_FLAG, CL_DRAW, CL_BCD, CL_STORE, CL_LOAD
    } cls_t;

    typedef struct packed {
        act_t act;
        logic cnt_inc;
    } cmd_t;

    typedef struct packed {
        logic       clr_done;
        logic [1:0] op_in;
        cls_t       cls;
        logic [3:0] cnt;
        logic [3:0] reg_x;
        logic       draw_end;
        logic       out_free;
    } sts_t;

    function automatic logic [7:0] font_byte(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] off;
        off = a - FONT_BASE;
        if (a >= FONT_BASE && a < FONT_BASE + 12'(FONT_BYTES)) begin
            return GLYPHS[off[6:0]];
        end
        return 8'h00;
    endfunction

endpackage
`default_nettype wire

// ----- src/c8core_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// c8core_ctrl
// Sequencer: clearing pass, fetch, decode, execute and multi-cycle walks.
// ----------------------------------------------------------------------------
module c8core_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output c8core_pkg::cmd_t      cmd,
    input  wire c8core_pkg::sts_t sts
);
    import c8core_pkg::*;

    typedef enum logic [17:0] {
        ST_CLEAR    = 18'b000000000000000001,
        ST_IDLE     = 18'b000000000000000010,
        ST_FETCH_HI = 18'b000000000000000100,
        ST_FETCH_LO = 18'b000000000000001000,
        ST_DECODE   = 18'b000000000000010000,
        ST_EXEC     = 18'b000000000000100000,
        ST_DRAW_RD  = 18'b000000000001000000,
        ST_DRAW_WR  = 18'b000000000010000000,
        ST_BCD      = 18'b000000000100000000,
        ST_STORE_RD = 18'b000000001000000000,
        ST_STORE_WR = 18'b000000010000000000,
        ST_LOAD_RD  = 18'b000000100000000000,
        ST_LOAD_WR  = 18'b000001000000000000,
        ST_WRITE_VF = 18'b000010000000000000,
        ST_WRITE_VX = 18'b000100000000000000,
        ST_TICK     = 18'b001000000000000000,
        ST_DONE     = 18'b010000000000000000,
        ST_SPARE    = 18'b100000000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd.act     = A_NONE;
        cmd.cnt_inc = 1'b0;
        s_tready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.act = A_CLEAR;
                if (sts.clr_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.act    = A_ACCEPT;
                    state_next = (sts.op_in == OP_EXEC) ? ST_FETCH_HI : ST_DONE;
                end
            end
            ST_FETCH_HI: begin
                cmd.act    = A_FETCH_HI;
                state_next = ST_FETCH_LO;
            end
            ST_FETCH_LO: begin
                cmd.act    = A_FETCH_LO;
                state_next = ST_DECODE;
            end
            ST_DECODE: begin
                cmd.act    = A_DECODE;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.act = A_EXEC;
                case (sts.cls)
                    CL_WX:    state_next = ST_WRITE_VX;
                    CL_FLAG:  state_next = ST_WRITE_VF;
                    CL_DRAW:  state_next = ST_DRAW_RD;
                    CL_BCD:   state_next = ST_BCD;
                    CL_STORE: state_next = ST_STORE_RD;
                    CL_LOAD:  state_next = ST_LOAD_RD;
                    default:  state_next = ST_TICK;
                endcase
            end
            ST_DRAW_RD: begin
                if (sts.draw_end) begin
                    state_next = ST_WRITE_VF;
                end else begin
                    cmd.act    = A_DRAW_RD;
                    state_next = ST_DRAW_WR;
                end
            end
            ST_DRAW_WR: begin
                cmd.act     = A_DRAW_WR;
                cmd.cnt_inc = 1'b1;
                state_next  = ST_DRAW_RD;
            end
            ST_BCD: begin
                cmd.act     = A_BCD;
                cmd.cnt_inc = 1'b1;
                if (sts.cnt == 4'd2) state_next = ST_TICK;
            end
            ST_STORE_RD: begin
                cmd.act    = A_STORE_RD;
                state_next = ST_STORE_WR;
            end
            ST_STORE_WR: begin
                cmd.act     = A_STORE_WR;
                cmd.cnt_inc = 1'b1;
                state_next  = (sts.cnt == sts.reg_x) ? ST_TICK : ST_STORE_RD;
            end
            ST_LOAD_RD: begin
                cmd.act    = A_LOAD_RD;
                state_next = ST_LOAD_WR;
            end
            ST_LOAD_WR: begin
                cmd.act     = A_LOAD_WR;
                cmd.cnt_inc = 1'b1;
                state_next  = (sts.cnt == sts.reg_x) ? ST_TICK : ST_LOAD_RD;
            end
            ST_WRITE_VF: begin
                cmd.act    = A_WRITE_VF;
                state_next = (sts.cls == CL_DRAW) ? ST_TICK : ST_WRITE_VX;
            end
            ST_WRITE_VX: begin
                cmd.act    = A_WRITE_VX;
                state_next = ST_TICK;
            end
            ST_TICK: begin
                cmd.act    = A_TICK;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.act    = A_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ----- src/c8core_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// c8core_dp
// Machine state, memories, instruction execution and the result register.
// ----------------------------------------------------------------------------
module c8core_dp (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire c8core_pkg::cmd_t                 cmd,
    output c8core_pkg::sts_t                      sts,
    input  wire logic [c8core_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire logic [1:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [c8core_pkg::M_DATA_W-1:0]       m_tdata
);
    import c8core_pkg::*;

    logic [7:0]        mem [MEM_BYTES];
    logic [7:0]        mem_q;
    logic [7:0]        rf [16];
    logic [15:0]       rf_valid_reg;
    logic [7:0]        va_q, vb_q;
    logic [SCREEN_W-1:0] frame [SCREEN_H];
    logic [SCREEN_H-1:0] fr_valid_reg;
    logic [SCREEN_W-1:0] fr_q;

    logic [ADDR_W-1:0] pc_reg;
    logic [15:0]       i_reg;
    logic [3:0]        sp_reg;
    logic [ADDR_W-1:0] stack_reg [STACK_DEPTH];
    logic [7:0]        dly_reg, snd_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              clr_done_reg;
    logic              m_valid_reg;

    logic [1:0]        op_sel_reg;
    logic [15:0]       keys_reg;
    logic [7:0]        rnd_reg;
    logic [7:0]        hi_reg;
    logic [15:0]       op_reg;
    logic [7:0]        res_reg;
    logic              flag_reg;
    logic [5:0]        px_reg;
    logic [4:0]        py_reg;
    logic [3:0]        cnt_reg;
    logic              inv_reg, wait_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic [3:0]  top, rx, ry, rn;
    logic [7:0]  kk;
    logic [11:0] nnn;
    logic        key_found;
    logic [3:0]  key_idx;
    logic        pressed;
    cls_t        cls;
    logic [7:0]  res;
    logic        flag;
    logic        skip;
    logic        invalid;
    logic [8:0]  sum9;
    logic [5:0]  row_sum;
    logic [4:0]  row_sel;
    logic [ADDR_W-1:0] i_addr;
    logic [SCREEN_W-1:0] mask;
    logic [7:0]  digit;
    logic [1:0]  hund;
    logic [6:0]  rem7;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [ADDR_W-1:0] mem_raddr;
    logic        mem_ren;
    logic        mem_wen;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]  mem_wdata;
    logic [3:0]  ra_addr;
    logic        rf_wen;
    logic [3:0]  rf_waddr;
    logic [7:0]  rf_wdata;

    assign top = op_reg[15:12];
    assign rx  = op_reg[11:8];
    assign ry  = op_reg[7:4];
    assign rn  = op_reg[3:0];
    assign kk  = op_reg[7:0];
    assign nnn = op_reg[11:0];

    always_comb begin
        key_found = 1'b0;
        key_idx   = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (keys_reg[k]) begin
                key_found = 1'b1;
                key_idx   = 4'(k);
            end
        end
    end

    assign pressed = (va_q[7:4] == 4'd0) && keys_reg[va_q[3:0]];
    assign sum9    = {1'b0, va_q} + {1'b0, vb_q};

    always_comb begin
        cls     = CL_NONE;
        res     = 8'h00;
        flag    = 1'b0;
        skip    = 1'b0;
        invalid = 1'b0;
        case (top)
            4'h0: invalid = (rn != 4'h0) && (rn != 4'hE);
            4'h3: skip = (va_q == kk);
            4'h4: skip = (va_q != kk);
            4'h5: skip = (va_q == vb_q);
            4'h6: begin cls = CL_WX; res = kk; end
            4'h7: begin cls = CL_WX; res = va_q + kk; end
            4'h8: begin
                case (rn)
                    4'h0: begin cls = CL_WX; res = vb_q; end
                    4'h1: begin cls = CL_WX; res = va_q | vb_q; end
                    4'h2: begin cls = CL_WX; res = va_q & vb_q; end
                    4'h3: begin cls = CL_WX; res = va_q ^ vb_q; end
                    4'h4: begin cls = CL_FLAG; res = sum9[7:0]; flag = sum9[8]; end
                    4'h5: begin cls = CL_FLAG; res = va_q - vb_q; flag = va_q >= vb_q; end
                    4'h6: begin cls = CL_FLAG; res = {1'b0, va_q[7:1]}; flag = va_q[0]; end
                    4'h7: begin cls = CL_FLAG; res = vb_q - va_q; flag = vb_q >= va_q; end
                    4'hE: begin cls = CL_FLAG; res = {va_q[6:0], 1'b0}; flag = va_q[7]; end
                    default: invalid = 1'b1;
                endcase
            end
            4'h9: skip = (va_q != vb_q);
            4'hC: begin cls = CL_WX; res = rnd_reg & kk; end
            4'hD: cls = CL_DRAW;
            4'hE: begin
                case (rn)
                    4'hE:    skip = pressed;
                    4'h1:    skip = !pressed;
                    default: invalid = 1'b1;
                endcase
            end
            4'hF: begin
                case (kk)
                    8'h07: begin cls = CL_WX; res = dly_reg; end
                    8'h0A: begin
                        cls = key_found ? CL_WX : CL_NONE;
                        res = {4'd0, key_idx};
                    end
                    8'h15, 8'h18, 8'h1E, 8'h29: invalid = 1'b0;
                    8'h33: cls = CL_BCD;
                    8'h55: cls = CL_STORE;
                    8'h65: cls = CL_LOAD;
                    default: invalid = 1'b1;
                endcase
            end
            default: invalid = 1'b0;
        endcase
    end

    assign row_sum = {1'b0, py_reg} + {2'b00, cnt_reg};
    assign row_sel = row_sum[4:0];
    assign i_addr  = i_reg[ADDR_W-1:0] + {8'd0, cnt_reg};
    assign mask    = {mem_q, 56'd0} >> px_reg;

    assign hund = (va_q >= 8'd200) ? 2'd2 : ((va_q >= 8'd100) ? 2'd1 : 2'd0);
    assign rem7 = 7'(va_q - 8'(hund) * 8'd100);
    assign prod = 15'(rem7) * 15'd205;
    assign tens = prod[14:11];

    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    digit = {6'd0, hund};
            2'd1:    digit = {4'd0, tens};
            default: digit = 8'(rem7 - 7'(tens) * 7'd10);
        endcase
    end

    always_comb begin
        mem_ren   = 1'b0;
        mem_raddr = i_addr;
        mem_wen   = 1'b0;
        mem_waddr = i_addr;
        mem_wdata = va_q;
        case (cmd.act)
            A_CLEAR: begin
                mem_wen   = !clr_done_reg;
                mem_waddr = clr_cnt_reg;
                mem_wdata = font_byte(clr_cnt_reg);
            end
            A_ACCEPT: begin
                mem_wen   = (s_tuser == OP_WRITE);
                mem_waddr = s_tdata[11:0];
                mem_wdata = s_tdata[19:12];
            end
            A_FETCH_HI: begin mem_ren = 1'b1; mem_raddr = pc_reg; end
            A_FETCH_LO: begin mem_ren = 1'b1; mem_raddr = pc_reg + 12'd1; end
            A_DRAW_RD, A_LOAD_RD: mem_ren = 1'b1;
            A_BCD: begin mem_wen = 1'b1; mem_wdata = digit; end
            A_STORE_WR: mem_wen = 1'b1;
            default: mem_ren = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_wen) mem[mem_waddr] <= mem_wdata;
        if (mem_ren) mem_q <= mem[mem_raddr];
    end

    assign ra_addr = (cmd.act == A_STORE_RD) ? cnt_reg :
                     ((hi_reg[7:4] == 4'hB) ? 4'h0 : hi_reg[3:0]);

    always_comb begin
        rf_wen   = 1'b0;
        rf_waddr = rx;
        rf_wdata = res_reg;
        case (cmd.act)
            A_WRITE_VF: begin rf_wen = 1'b1; rf_waddr = 4'hF; rf_wdata = {7'd0, flag_reg}; end
            A_WRITE_VX: rf_wen = 1'b1;
            A_LOAD_WR:  begin rf_wen = 1'b1; rf_waddr = cnt_reg; rf_wdata = mem_q; end
            default:    rf_wen = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rf_wen) rf[rf_waddr] <= rf_wdata;
        if (cmd.act == A_DECODE || cmd.act == A_STORE_RD) begin
            va_q <= rf_valid_reg[ra_addr] ? rf[ra_addr] : 8'h00;
        end
        if (cmd.act == A_DECODE) begin
            vb_q <= rf_valid_reg[mem_q[7:4]] ? rf[mem_q[7:4]] : 8'h00;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.act == A_DRAW_WR) frame[row_sel] <= fr_q ^ mask;
        if (cmd.act == A_ACCEPT) begin
            fr_q <= fr_valid_reg[s_tdata[24:20]] ? frame[s_tdata[24:20]] : '0;
        end else if (cmd.act == A_DRAW_RD) begin
            fr_q <= fr_valid_reg[row_sel] ? frame[row_sel] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= PROGRAM_BASE;
            i_reg        <= '0;
            sp_reg       <= '0;
            dly_reg      <= '0;
            snd_reg      <= '0;
            rf_valid_reg <= '0;
            fr_valid_reg <= '0;
            clr_cnt_reg  <= '0;
            clr_done_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int s = 0; s < STACK_DEPTH; s++) stack_reg[s] <= '0;
        end else begin
            if (cmd.act != A_OUT && m_tready) m_valid_reg <= 1'b0;
            if (rf_wen) rf_valid_reg[rf_waddr] <= 1'b1;
            case (cmd.act)
                A_CLEAR: begin
                    if (!clr_done_reg) begin
                        clr_cnt_reg <= clr_cnt_reg + 12'd1;
                        if (clr_cnt_reg == ADDR_LAST) clr_done_reg <= 1'b1;
                    end
                end
                A_DECODE: pc_reg <= pc_reg + 12'd2;
                A_EXEC: begin
                    if (skip) pc_reg <= pc_reg + 12'd2;
                    case (top)
                        4'h0: begin
                            if (rn == 4'h0) fr_valid_reg <= '0;
                            if (rn == 4'hE) begin
                                sp_reg <= sp_reg - 4'd1;
                                pc_reg <= stack_reg[sp_reg - 4'd1];
                            end
                        end
                        4'h1: pc_reg <= nnn;
                        4'h2: begin
                            stack_reg[sp_reg] <= pc_reg;
                            sp_reg            <= sp_reg + 4'd1;
                            pc_reg            <= nnn;
                        end
                        4'hA: i_reg <= {4'd0, nnn};
                        4'hB: pc_reg <= {4'd0, va_q} + nnn;
                        4'hF: begin
                            case (kk)
                                8'h0A: if (!key_found) pc_reg <= pc_reg - 12'd2;
                                8'h15: dly_reg <= va_q;
                                8'h18: snd_reg <= va_q;
                                8'h1E: i_reg <= i_reg + {8'd0, va_q};
                                8'h29: i_reg <= {4'd0, FONT_BASE} + {6'd0, va_q, 2'b00}
                                               + {8'd0, va_q};
                                default: i_reg <= i_reg;
                            endcase
                        end
                        default: i_reg <= i_reg;
                    endcase
                end
                A_DRAW_WR: fr_valid_reg[row_sel] <= 1'b1;
                A_TICK: begin
                    if (dly_reg != 8'd0) dly_reg <= dly_reg - 8'd1;
                    if (snd_reg != 8'd0) snd_reg <= snd_reg - 8'd1;
                end
                A_OUT: m_valid_reg <= 1'b1;
                default: i_reg <= i_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cnt_inc) cnt_reg <= cnt_reg + 4'd1;
        case (cmd.act)
            A_ACCEPT: begin
                op_sel_reg <= s_tuser;
                keys_reg   <= s_tdata[40:25];
                rnd_reg    <= s_tdata[48:41];
                inv_reg    <= 1'b0;
                wait_reg   <= 1'b0;
                op_reg     <= '0;
            end
            A_FETCH_LO: hi_reg <= mem_q;
            A_DECODE:   op_reg <= {hi_reg, mem_q};
            A_EXEC: begin
                res_reg  <= res;
                flag_reg <= flag;
                px_reg   <= va_q[5:0];
                py_reg   <= vb_q[4:0];
                cnt_reg  <= '0;
                inv_reg  <= invalid;
                wait_reg <= (top == 4'hF) && (kk == 8'h0A) && !key_found;
            end
            A_DRAW_WR: if (|(fr_q & mask)) flag_reg <= 1'b1;
            A_OUT: begin
                m_data_reg <= {1'b0,
                               (op_sel_reg == OP_READ) ? fr_q : {SCREEN_W{1'b0}},
                               snd_reg != 8'd0, wait_reg, inv_reg, pc_reg,
                               (op_sel_reg == OP_EXEC) ? op_reg : 16'h0000};
            end
            default: hi_reg <= hi_reg;
        endcase
    end

    assign sts.clr_done = clr_done_reg;
    assign sts.op_in    = s_tuser;
    assign sts.cls      = cls;
    assign sts.cnt      = cnt_reg;
    assign sts.reg_x    = rx;
    assign sts.draw_end = (cnt_reg == rn) || row_sum[5];
    assign sts.out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

// ----- src/chip8_interpreter_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_interpreter_core
// CHIP-8 machine: 4 KB memory, registers, stack, timers and 64x32 display.
// ----------------------------------------------------------------------------
// Each request on the s_ channel is one operation chosen by s_tuser: write a
// memory byte, run one instruction cycle, or read one display row. Each
// request yields exactly one result on the m_ channel.
// One request is handled at a time. A byte write or row read goes to the
// result register; an instruction cycle fetches both opcode bytes, decodes and
// executes, then as the opcode needs writes a register (flag first), writes the
// BCD digits, walks Fx55/Fx65 one register at a time or Dxyn one sprite row at
// a time (flag last), and ends with a timer tick. The memory has a single read
// and a single write port, which sets these walks. After reset a clearing pass
// loads the font and zeros all other memory; s_tready stays low until it ends.
// The result register parts the channels: the next request is taken while a
// result waits, and a stalled receiver holds the block only when a second
// result is ready.
// ----------------------------------------------------------------------------
module chip8_interpreter_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // address, write_byte, display_row, keys_down, random_byte
    input  wire logic [55:0] s_tdata,
    // operation
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // fetched_opcode, next_pc, invalid_opcode, key_wait, sound_on, row_pixels
    output logic [95:0]      m_tdata
);
    import c8core_pkg::*;

    cmd_t cmd;
    sts_t sts;

    c8core_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    c8core_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

// ----- src/c8core_chk.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// c8core_chk
// Port-level checks of the CHIP-8 interpreter core.
// ----------------------------------------------------------------------------
module c8core_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [55:0] s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[28] && m_tdata[29]))
        else $error("invalid opcode and key wait together");

    a_wait_op: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[29] |-> m_tdata[15:12] == 4'hF && m_tdata[7:0] == 8'h0A)
        else $error("key wait on wrong opcode");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("outputs active after reset");

endmodule

bind chip8_interpreter_core c8core_chk u_chk (.*);
`default_nettype wire

// ----- tb/chip8_interpreter_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chip8_interpreter_core_tb
// Checks the CHIP-8 core against a cycle-free machine model of its own.
// ----------------------------------------------------------------------------
// Every request is predicted when it is generated: byte writes place opcodes
// at the predicted PC, so most instruction cycles run well-formed programs
// with random operands, keys and random bytes. A directed prologue covers
// flag order, sprite clipping, key waits, stack wrap, address wrap, unknown
// opcodes and the unknown operation. Both channels idle at random; the
// receiver holds off once for a long stretch and the sender drains once.
// ----------------------------------------------------------------------------
module chip8_interpreter_core_tb;
    import c8core_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [11:0] addr;
        logic [7:0]  wbyte;
        logic [4:0]  row;
        logic [15:0] keys;
        logic [7:0]  rnd;
        bit          drain;
    } req_t;

    typedef struct {
        logic [15:0] opcode;
        logic [11:0] pc;
        logic        bad;
        logic        kwait;
        logic        snd;
        logic [63:0] pix;
    } res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;

    req_t pend_q[$];
    res_t want_q[$];
    int   sent_cnt = 0;
    int   got_cnt = 0;
    int   err_cnt = 0;
    int   cyc = 0;
    int   hold_left = 0;
    bit   hold_done = 0;
    bit   quiet;

    // machine model
    logic [7:0]  mem [MEM_BYTES];
    logic [7:0]  vr [16];
    logic [15:0] idx;
    logic [11:0] pc;
    logic [11:0] stk [16];
    logic [3:0]  sp;
    logic [7:0]  dly, snd;
    logic [63:0] fb [32];

    chip8_interpreter_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    assign quiet = (cyc >= 6000 && cyc < 9000);

    task automatic skip_if(input bit c);
        if (c) pc = pc + 12'd2;
    endtask

    function automatic bit key_hit(input logic [7:0] k, input logic [15:0] keys);
        if (k > 8'd15) return 0;
        return keys[k[3:0]];
    endfunction

    task automatic draw(input int x, input int y, input int n);
        int px, py, r, c, rr, col;
        logic [7:0]  bits;
        logic [63:0] m;
        px = vr[x] % 64;
        py = vr[y] % 32;
        vr[15] = 8'd0;
        for (r = 0; r < n; r++) begin
            bits = mem[12'(idx + 16'(r))];
            rr = py + r;
            if (rr >= 32) break;
            for (c = 0; c < 8; c++) begin
                col = px + c;
                if (col >= 64) break;
                if (bits[7-c]) begin
                    m = 64'd1 << (63 - col);
                    if ((fb[rr] & m) != 0) vr[15] = 8'd1;
                    fb[rr] ^= m;
                end
            end
        end
    endtask

    task automatic run_opcode(input logic [15:0] o, input logic [15:0] keys,
                              input logic [7:0] rnd, output bit ok, output bit kw);
        int x, y, n, i;
        logic [7:0]  kk, a, b;
        logic [11:0] nnn;
        x = o[11:8]; y = o[7:4]; n = o[3:0];
        kk = o[7:0]; nnn = o[11:0];
        a = vr[x]; b = vr[y];
        ok = 1; kw = 0;
        case (o[15:12])
            4'h0: begin
                if (n == 0) begin
                    for (i = 0; i < 32; i++) fb[i] = '0;
                end else if (n == 14) begin
                    sp = sp - 4'd1;
                    pc = stk[sp];
                end else ok = 0;
            end
            4'h1: pc = nnn;
            4'h2: begin stk[sp] = pc; sp = sp + 4'd1; pc = nnn; end
            4'h3: skip_if(a == kk);
            4'h4: skip_if(a != kk);
            4'h5: skip_if(a == b);
            4'h6: vr[x] = kk;
            4'h7: vr[x] = a + kk;
            4'h8: case (n)
                0: vr[x] = b;
                1: vr[x] = a | b;
                2: vr[x] = a & b;
                3: vr[x] = a ^ b;
                4: begin vr[15] = 8'((9'(a) + 9'(b)) > 9'd255); vr[x] = a + b; end
                5: begin vr[15] = 8'(a >= b); vr[x] = a - b; end
                6: begin vr[15] = 8'(a[0]); vr[x] = a >> 1; end
                7: begin vr[15] = 8'(b >= a); vr[x] = b - a; end
                14: begin vr[15] = 8'(a[7]); vr[x] = a << 1; end
                default: ok = 0;
            endcase
            4'h9: skip_if(a != b);
            4'hA: idx = 16'(nnn);
            4'hB: pc = 12'(vr[0]) + nnn;
            4'hC: vr[x] = rnd & kk;
            4'hD: draw(x, y, n);
            4'hE: begin
                if (n == 14) skip_if(key_hit(a, keys));
                else if (n == 1) skip_if(!key_hit(a, keys));
                else ok = 0;
            end
            default: case (kk)
                8'h07: vr[x] = dly;
                8'h0A: begin
                    kw = 1;
                    for (i = 0; i < 16; i++) begin
                        if (kw && keys[i]) begin vr[x] = 8'(i); kw = 0; end
                    end
                    if (kw) pc = pc - 12'd2;
                end
                8'h15: dly = a;
                8'h18: snd = a;
                8'h1E: idx = idx + 16'(a);
                8'h29: idx = 16'd80 + 16'(5 * int'(a));
                8'h33: begin
                    mem[12'(idx)] = a / 100;
                    mem[12'(idx + 16'd1)] = (a / 10) % 10;
                    mem[12'(idx + 16'd2)] = a % 10;
                end
                8'h55: for (i = 0; i <= x; i++) mem[12'(idx + 16'(i))] = vr[i];
                8'h65: for (i = 0; i <= x; i++) vr[i] = mem[12'(idx + 16'(i))];
                default: ok = 0;
            endcase
        endcase
    endtask

    task automatic predict(input req_t q, output res_t r);
        bit ok, kw;
        r = '{default: '0};
        if (q.op == OP_WRITE) begin
            mem[q.addr] = q.wbyte;
        end else if (q.op == OP_EXEC) begin
            r.opcode = {mem[pc], mem[pc + 12'd1]};
            pc = pc + 12'd2;
            run_opcode(r.opcode, q.keys, q.rnd, ok, kw);
            if (dly != 0) dly--;
            if (snd != 0) snd--;
            r.bad = !ok;
            r.kwait = kw;
        end else if (q.op == OP_READ) begin
            r.pix = fb[q.row];
        end
        r.pc = pc;
        r.snd = (snd != 0);
    endtask

    task automatic add_req(input logic [1:0] op, input logic [11:0] addr,
                           input logic [7:0] wb, input logic [4:0] row,
                           input logic [15:0] keys, input logic [7:0] rnd,
                           input bit drain);
        req_t q;
        res_t r;
        q = '{op, addr, wb, row, keys, rnd, drain};
        predict(q, r);
        pend_q.push_back(q);
        want_q.push_back(r);
    endtask

    // place an opcode at the PC, then run it
    task automatic add_prog(input logic [15:0] o, input logic [15:0] keys,
                            input logic [7:0] rnd);
        add_req(OP_WRITE, pc, o[15:8], '0, '0, '0, 0);
        add_req(OP_WRITE, pc + 12'd1, o[7:0], '0, '0, '0, 0);
        add_req(OP_EXEC, '0, '0, '0, keys, rnd, 0);
    endtask

    function automatic logic [15:0] rand_opcode();
        logic [15:0] o;
        logic [7:0]  fk [9] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33,
                                8'h55, 8'h65};
        int          e8 [9] = '{0, 1, 2, 3, 4, 5, 6, 7, 14};
        o = 16'($urandom);
        if ($urandom_range(0, 9) == 0) return o;
        case (o[15:12])
            4'h0: o[11:0] = $urandom_range(0, 1) ? 12'h0E0 : 12'h0EE;
            4'h8: o[3:0] = 4'(e8[$urandom_range(0, 8)]);
            4'hD: o[3:0] = 4'($urandom_range(0, 6));
            4'hE: o[7:0] = $urandom_range(0, 1) ? 8'h9E : 8'hA1;
            4'hF: o[7:0] = fk[$urandom_range(0, 8)];
            default: ;
        endcase
        return o;
    endfunction

    task automatic report(input string what, input logic [95:0] got,
                          input logic [95:0] exp);
        $display("mismatch at result %0d: %s got %h expected %h", got_cnt, what,
                 got, exp);
        err_cnt++;
    endtask

    // stimulus
    initial begin
        int i, k, nrand;
        logic [15:0] keys;
        bit drained;
        for (i = 0; i < MEM_BYTES; i++) mem[i] = 8'd0;
        for (i = 0; i < FONT_BYTES; i++) mem[80 + i] = GLYPHS[i];
        for (i = 0; i < 16; i++) begin vr[i] = '0; stk[i] = '0; end
        for (i = 0; i < 32; i++) fb[i] = '0;
        idx = '0; pc = PROGRAM_BASE; sp = '0; dly = '0; snd = '0;
        drained = 0;

        add_prog(16'h60FF, '0, '0);
        add_prog(16'h6F01, '0, '0);
        add_prog(16'h8F04, '0, '0);
        add_prog(16'h8F05, '0, '0);
        add_prog(16'h603E, '0, '0);
        add_prog(16'h611F, '0, '0);
        add_prog(16'hA050, '0, '0);
        add_prog(16'hD01F, '0, '0);
        add_req(OP_READ, '0, '0, 5'd31, '0, '0, 0);
        add_prog(16'hE09E, 16'hFFFF, '0);
        add_prog(16'hF00A, 16'h0000, '0);
        add_prog(16'hF10A, 16'h8000, '0);
        add_prog(16'h0001, '0, '0);
        add_prog(16'hF018, '0, 8'hFF);
        add_req(OP_NONE, 12'hFFF, 8'hFF, 5'd31, 16'hFFFF, 8'hFF, 0);
        add_prog(16'h1FFE, '0, '0);
        add_prog(16'hC5FF, '0, 8'hA5);
        add_prog(16'h00EE, '0, '0);
        add_prog(16'h00E0, '0, '0);
        add_req(OP_READ, '0, '0, 5'd0, '0, '0, 0);

        nrand = 0;
        while (nrand < 950) begin
            k = $urandom_range(0, 99);
            keys = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom);
            if (!drained && nrand >= 500) begin
                add_req(OP_READ, '0, '0, 5'($urandom), keys, '0, 1);
                drained = 1;
                nrand++;
            end else if (k < 70) begin
                add_prog(rand_opcode(), keys, 8'($urandom));
                nrand += 3;
            end else if (k < 80) begin
                add_req(OP_EXEC, '0, '0, '0, keys, 8'($urandom), 0);
                nrand++;
            end else if (k < 88) begin
                add_req(OP_READ, '0, '0, 5'($urandom), keys, 8'($urandom), 0);
                nrand++;
            end else if (k < 97) begin
                add_req(OP_WRITE, 12'($urandom), 8'($urandom), 5'($urandom), keys,
                        8'($urandom), 0);
                nrand++;
            end else begin
                add_req(OP_NONE, 12'($urandom), 8'($urandom), 5'($urandom), keys,
                        8'($urandom), 0);
                nrand++;
            end
        end

        k = pend_q.size();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        wait (sent_cnt == k && got_cnt == k);
        repeat (60) @(posedge aclk);
        if (err_cnt == 0 && want_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > 600000) begin
            $display("simulation failed");
            $finish;
        end
    end

    // driver
    always @(posedge aclk) begin
        bit   go;
        req_t q;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) sent_cnt++;
            if (!s_tvalid || s_tready) begin
                go = pend_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 11);
                if (go && pend_q[0].drain && got_cnt != sent_cnt) go = 0;
                if (go) begin
                    q = pend_q.pop_front();
                    s_tdata <= {7'd0, q.rnd, q.keys, q.row, q.wbyte, q.addr};
                    s_tuser <= q.op;
                end
                s_tvalid <= go;
            end
        end
    end

    // receiver ready, with one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (!hold_done && got_cnt >= 400) begin
                hold_done = 1;
                hold_left = 300;
            end
            if (hold_left > 0) hold_left--;
            m_tready <= hold_left == 0 && (quiet || $urandom_range(0, 99) >= 11);
        end
    end

    // monitor
    always @(posedge aclk) begin
        res_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (want_q.size() == 0) begin
                report("unexpected result", m_tdata, '0);
            end else begin
                w = want_q.pop_front();
                if (m_tdata[15:0] !== w.opcode) report("opcode", m_tdata[15:0], w.opcode);
                if (m_tdata[27:16] !== w.pc) report("next_pc", m_tdata[27:16], w.pc);
                if (m_tdata[28] !== w.bad) report("invalid", m_tdata[28], w.bad);
                if (m_tdata[29] !== w.kwait) report("key_wait", m_tdata[29], w.kwait);
                if (m_tdata[30] !== w.snd) report("sound_on", m_tdata[30], w.snd);
                if (m_tdata[94:31] !== w.pix) report("row", m_tdata[94:31], w.pix);
            end
            got_cnt++;
        end
    end

endmodule
